/* rtl/fixed_point_alu_macros.svh */
// Assertion macros shared by the fixed-point ALU RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising clock edge outside of reset.
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FPA_ASSERT(lbl, clk, rst_n, prop, msg)

`define FPA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/fpa_pkg.sv */
`default_nettype none

package fpa_pkg;

  // Width of one raw fixed-point value.
  localparam int RAW_W = 32;

  localparam logic signed [63:0] RAW_MAX = 64'sd2147483647;
  localparam logic signed [63:0] RAW_MIN = -64'sd2147483648;

  // Operation codes; code 15 is unused and yields an all-zero result.
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_GT     = 4'd4,
    OP_LT     = 4'd5,
    OP_GE     = 4'd6,
    OP_LE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_INC    = 4'd10,
    OP_DEC    = 4'd11,
    OP_MIN    = 4'd12,
    OP_MAX    = 4'd13,
    OP_TO_INT = 4'd14
  } op_t;

  // A value clipped to the 32-bit range, with the flag that says so.
  typedef struct packed {
    logic signed [RAW_W-1:0] value;
    logic                    sat;
  } clip_t;

  // Clip a wide signed result to the signed 32-bit range.
  function automatic clip_t clip64(input logic signed [63:0] x);
    clip_t c;
    if (x > RAW_MAX) begin
      c.value = RAW_MAX[RAW_W-1:0];
      c.sat   = 1'b1;
    end else if (x < RAW_MIN) begin
      c.value = RAW_MIN[RAW_W-1:0];
      c.sat   = 1'b1;
    end else begin
      c.value = x[RAW_W-1:0];
      c.sat   = 1'b0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/fpa_div.sv */
`default_nettype none

// Pipelined restoring divider for unsigned magnitudes. One quotient bit is
// resolved per stage, followed by a stage that rounds half away from zero.
module fpa_div #(
  parameter int NUM_W = 40
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [NUM_W-1:0]            num_i,
  input  wire logic [fpa_pkg::RAW_W-1:0]   den_i,
  output logic      [NUM_W-1:0]            quo_o
);
  import fpa_pkg::*;

  // Per-stage partial remainder, numerator/quotient shift word and divisor.
  logic [RAW_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] qn_r  [NUM_W];
  logic [RAW_W-1:0] den_r [NUM_W];
  logic [NUM_W-1:0] quo_r;

  // Stage inputs: the first stage starts from a zero remainder.
  logic [RAW_W-1:0] rem_in [NUM_W];
  logic [NUM_W-1:0] qn_in  [NUM_W];
  logic [RAW_W-1:0] den_in [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [RAW_W:0]   trial;
    logic [RAW_W:0]   diff;
    logic             ge;
    logic [RAW_W-1:0] rem_nxt;
    logic [NUM_W-1:0] qn_nxt;

    if (k == 0) begin : g_first
      assign rem_in[k] = '0;
      assign qn_in[k]  = num_i;
      assign den_in[k] = den_i;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign qn_in[k]  = qn_r[k-1];
      assign den_in[k] = den_r[k-1];
    end

    // Shift in the next numerator bit and subtract when it fits.
    always_comb begin
      trial   = {rem_in[k], qn_in[k][NUM_W-1]};
      diff    = trial - {1'b0, den_in[k]};
      ge      = (trial >= {1'b0, den_in[k]});
      rem_nxt = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
      qn_nxt  = {qn_in[k][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        qn_r[k]  <= qn_nxt;
        den_r[k] <= den_in[k];
      end
    end
  end

  // Round up when the remainder is at least half of the divisor.
  logic             round_up;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    round_up = ({rem_r[NUM_W-1], 1'b0} >= {1'b0, den_r[NUM_W-1]});
    quo_nxt  = qn_r[NUM_W-1] + NUM_W'(round_up);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo_o = quo_r;

endmodule

`default_nettype wire

/* rtl/fixed_point_alu.sv */
`default_nettype none
`include "fixed_point_alu_macros.svh"

// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits.
// Each input transaction carries an opcode in in_tuser and the two operands
// in in_tdata, and yields exactly one output transaction in order. Multiply,
// divide and to_int round half away from zero; add, subtract, multiply,
// divide, increment and decrement saturate to the 32-bit range and flag it.
// A divide by zero returns zero with the divide_by_zero flag. The block takes
// one transaction per cycle, and the divider resolves one quotient bit per
// pipeline stage over 32 + FRAC_BITS stages.
// The whole pipeline holds while a finished result waits on out_tready.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  wire logic [3:0]  in_tuser,   // [3:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] value
  output logic [2:0]       out_tuser   // [0] compare_true, [1] saturated,
                                       // [2] divide_by_zero
);
  import fpa_pkg::*;

  localparam int NUM_W = RAW_W + FRAC_BITS;
  localparam int DEPTH = NUM_W + 1;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // Side band that travels beside the divider.
  typedef struct packed {
    op_t                     op;
    logic signed [RAW_W-1:0] value;
    logic                    cmp;
    logic                    sat;
    logic signed [63:0]      wide;
    logic                    neg;
    logic                    dz;
  } sb_t;

  // x / 2^FRAC_BITS rounded half away from zero.
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + HALF - $signed({63'd0, x[63]});
    return t >>> FRAC_BITS;
  endfunction

  // The whole pipeline moves when the output register is free or drained.
  // Nothing is taken in while reset is applied.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && rst_n;

  // Stage A: input register.
  logic                    va_r;
  op_t                     op_a_r;
  logic signed [RAW_W-1:0] a_r;
  logic signed [RAW_W-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_a_r <= op_t'(in_tuser);
      a_r    <= in_tdata[31:0];
      b_r    <= in_tdata[63:32];
    end
  end

  // Stage B: one add, the compares, the product and the divider operands.
  logic [RAW_W-1:0]        addend;
  logic                    cin;
  logic [RAW_W:0]          sum_nxt;
  logic signed [63:0]      prod_nxt;
  logic [RAW_W-1:0]        mag_a;
  logic [RAW_W-1:0]        mag_b;

  always_comb begin
    unique case (op_a_r)
      OP_SUB: begin
        addend = ~b_r;
        cin    = 1'b1;
      end
      OP_INC: begin
        addend = RAW_W'(1);
        cin    = 1'b0;
      end
      OP_DEC: begin
        addend = '1;
        cin    = 1'b0;
      end
      default: begin
        addend = b_r;
        cin    = 1'b0;
      end
    endcase
    sum_nxt  = {a_r[RAW_W-1], a_r} + {addend[RAW_W-1], addend} + (RAW_W+1)'(cin);
    prod_nxt = 64'(a_r) * 64'(b_r);
    mag_a    = a_r[RAW_W-1] ? RAW_W'(-a_r) : a_r;
    mag_b    = b_r[RAW_W-1] ? RAW_W'(-b_r) : b_r;
  end

  logic                    vb_r;
  op_t                     op_b_r;
  logic signed [RAW_W-1:0] a_b_r;
  logic signed [RAW_W-1:0] b_b_r;
  logic [RAW_W:0]          sum_r;
  logic                    lt_r;
  logic                    eq_r;
  logic signed [63:0]      prod_r;
  logic                    neg_div_r;
  logic                    dz_r;
  logic [NUM_W-1:0]        num_r;
  logic [RAW_W-1:0]        den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_b_r    <= op_a_r;
      a_b_r     <= a_r;
      b_b_r     <= b_r;
      sum_r     <= sum_nxt;
      lt_r      <= (a_r < b_r);
      eq_r      <= (a_r == b_r);
      prod_r    <= prod_nxt;
      neg_div_r <= a_r[RAW_W-1] ^ b_r[RAW_W-1];
      dz_r      <= (b_r == '0);
      num_r     <= {mag_a, FRAC_BITS'(0)};
      den_r     <= mag_b;
    end
  end

  // Divider pipeline, started from the stage B registers.
  logic [NUM_W-1:0] quo;

  fpa_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .en    (adv),
    .num_i (num_r),
    .den_i (den_r),
    .quo_o (quo)
  );

  // Stage C: clip the sums, resolve compares, min and max, and round product or to_int.
  sb_t                sb_nxt;
  logic               ovf;
  logic signed [63:0] rin;

  always_comb begin
    ovf    = sum_r[RAW_W] ^ sum_r[RAW_W-1];
    rin    = (op_b_r == OP_TO_INT) ? 64'(a_b_r) : prod_r;
    sb_nxt = '0;
    sb_nxt.op   = op_b_r;
    sb_nxt.wide = round_shift(rin);
    unique case (op_b_r)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (ovf) begin
          sb_nxt.value = sum_r[RAW_W] ? RAW_MIN[RAW_W-1:0] : RAW_MAX[RAW_W-1:0];
        end else begin
          sb_nxt.value = sum_r[RAW_W-1:0];
        end
        sb_nxt.sat = ovf;
      end
      OP_DIV: begin
        sb_nxt.neg = neg_div_r;
        sb_nxt.dz  = dz_r;
      end
      OP_GT: sb_nxt.cmp = !lt_r && !eq_r;
      OP_LT: sb_nxt.cmp = lt_r;
      OP_GE: sb_nxt.cmp = !lt_r;
      OP_LE: sb_nxt.cmp = lt_r || eq_r;
      OP_EQ: sb_nxt.cmp = eq_r;
      OP_NE: sb_nxt.cmp = !eq_r;
      OP_MIN: sb_nxt.value = lt_r ? a_b_r : b_b_r;
      OP_MAX: sb_nxt.value = (!lt_r && !eq_r) ? a_b_r : b_b_r;
      default: begin
        sb_nxt.neg = 1'b0;
      end
    endcase
  end

  // Delay line that keeps the side band aligned with the divider.
  logic vs_r [DEPTH];
  sb_t  sb_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        vs_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vs_r[0] <= vb_r;
      for (int i = 1; i < DEPTH; i++) begin
        vs_r[i] <= vs_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i < DEPTH; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // Final stage: sign and clip the wide results, then select.
  sb_t                     sb_last;
  logic signed [63:0]      qs;
  clip_t                   cl;
  logic signed [RAW_W-1:0] value_nxt;
  logic [2:0]              flags_nxt;

  always_comb begin
    sb_last = sb_r[DEPTH-1];
    qs      = $signed(64'(quo));
    if (sb_last.neg) begin
      qs = -qs;
    end
    cl = clip64((sb_last.op == OP_DIV) ? qs : sb_last.wide);
    unique case (sb_last.op)
      OP_DIV: begin
        if (sb_last.dz) begin
          value_nxt = '0;
          flags_nxt = 3'b100;
        end else begin
          value_nxt = cl.value;
          flags_nxt = {1'b0, cl.sat, 1'b0};
        end
      end
      OP_MUL, OP_TO_INT: begin
        value_nxt = cl.value;
        flags_nxt = {1'b0, cl.sat, 1'b0};
      end
      default: begin
        value_nxt = sb_last.value;
        flags_nxt = {1'b0, sb_last.sat, sb_last.cmp};
      end
    endcase
  end

  // Output register.
  logic                    out_valid_r;
  logic signed [RAW_W-1:0] out_value_r;
  logic [2:0]              out_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vs_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= value_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_flags_r;

  // A divide by zero reports a zero value and no saturation.
  `FPA_ASSERT(a_dz_zero, clk, rst_n, out_tvalid && out_tuser[2] |-> out_tdata == '0 && !out_tuser[1], "divide by zero with nonzero value or saturation")
  // Comparisons return a zero value.
  `FPA_ASSERT(a_cmp_zero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata == '0, "comparison result with nonzero value")
  // A result is never both a comparison and saturated.
  `FPA_ASSERT(a_cmp_sat, clk, rst_n, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "comparison flagged as saturated")
  // Nothing leaves the block in the cycle after reset.
  `FPA_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

/* tb/tb_fixed_point_alu.sv */
// Testbench for the fixed-point ALU.
//
// Every transaction accepted on the input stream is run through a local
// predictor that works in exact 64-bit integer arithmetic. The predicted result
// is queued, and each transaction on the output stream is checked field by field
// against the oldest entry in that queue.
//
// The stimulus runs in three parts. A short directed set covers the range limits,
// every opcode, rounding ties and the divide-by-zero case. A random part follows,
// with idle bursts on both streams and one long receiver hold-off that backs up
// the pipeline. A last random part runs at full rate with no idling.
module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int FRAC_BITS  = 8;
  // Drain for the pipeline depth with some margin on top.
  localparam int DRAIN_CYCLES = 36 + FRAC_BITS + 20;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [3:0] OP_UNUSED = 4'd15;
  localparam logic signed [31:0] RAW_HI = 32'sh7fff_ffff;
  localparam logic signed [31:0] RAW_LO = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               sat;
    logic               dz;
  } alu_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  alu_item_t   pending_ops[$];
  alu_result_t expected_results[$];
  int          mismatch_count;
  bit          in_accepted;
  bit          idle_off;
  bit          hold_request;
  bit          hold_active;
  int          send_gap;
  int          stall_gap;

  fixed_point_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Clip a wide result to the signed 32-bit range and flag any clipping.
  function automatic alu_result_t saturate_raw(input longint x);
    alu_result_t res;
    res = '0;
    if (x > longint'(RAW_HI)) begin
      res.value = RAW_HI;
      res.sat   = 1'b1;
    end else if (x < longint'(RAW_LO)) begin
      res.value = RAW_LO;
      res.sat   = 1'b1;
    end else begin
      res.value = x[31:0];
    end
    return res;
  endfunction

  // Divide by 2^FRAC_BITS, rounding half away from zero.
  function automatic longint round_frac(input longint x);
    logic [63:0] mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Expected result of one ALU operation.
  function automatic alu_result_t alu_predict(input alu_item_t it);
    alu_result_t res;
    longint      a;
    longint      b;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    res = '0;
    a = it.a;
    b = it.b;
    case (it.op)
      OP_ADD: res = saturate_raw(a + b);
      OP_SUB: res = saturate_raw(a - b);
      OP_MUL: res = saturate_raw(round_frac(a * b));
      OP_DIV: begin
        if (b == 0) begin
          res.dz = 1'b1;
        end else begin
          num = ((a < 0) ? -a : a) << FRAC_BITS;
          den = (b < 0) ? -b : b;
          quo = num / den;
          rem = num % den;
          if (rem >= den - rem) quo = quo + 1;
          res = saturate_raw(((a < 0) != (b < 0)) ? -longint'(quo) : longint'(quo));
        end
      end
      OP_GT:     res.cmp = (a > b);
      OP_LT:     res.cmp = (a < b);
      OP_GE:     res.cmp = (a >= b);
      OP_LE:     res.cmp = (a <= b);
      OP_EQ:     res.cmp = (a == b);
      OP_NE:     res.cmp = (a != b);
      OP_INC:    res = saturate_raw(a + 1);
      OP_DEC:    res = saturate_raw(a - 1);
      OP_MIN:    res.value = (a < b) ? it.a : it.b;
      OP_MAX:    res.value = (a > b) ? it.a : it.b;
      OP_TO_INT: res.value = 32'(round_frac(a));
      default:   res = '0;
    endcase
    return res;
  endfunction

  // Operand mix: range limits, small values, scaled and full-width random values.
  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return int'($urandom);
      1: return int'($urandom_range(0, 2048)) - 1024;
      2: begin
        case ($urandom_range(0, 6))
          0: return RAW_HI;
          1: return RAW_LO;
          2: return RAW_HI - 1;
          3: return RAW_LO + 1;
          4: return 32'sd1;
          5: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return int'($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  task automatic push_item(input logic [3:0] op, input logic signed [31:0] a,
                           input logic signed [31:0] b);
    alu_item_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    pending_ops.push_back(it);
  endtask

  task automatic queue_random(input int count);
    alu_item_t it;
    for (int i = 0; i < count; i++) begin
      it.op = 4'($urandom_range(0, 15));
      it.a  = rand_operand();
      it.b  = ($urandom_range(0, 5) == 0) ? it.a : rand_operand();
      if (it.op == OP_DIV && $urandom_range(0, 7) == 0) it.b = 0;
      pending_ops.push_back(it);
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Input driver: presents the oldest pending transaction, with idle bursts.
  always @(negedge clk) begin : drive_inputs
    bit holding;
    holding = in_tvalid && !in_accepted;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!holding) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 15);
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_ops[0].b, pending_ops[0].a};
        in_tuser  <= pending_ops[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stall bursts plus the long hold-off.
  always @(negedge clk) begin
    if (!rst_n || hold_active) begin
      out_tready <= 1'b0;
    end else if (stall_gap > 0) begin
      stall_gap--;
      out_tready <= 1'b0;
    end else if (!idle_off && $urandom_range(0, 9) == 0) begin
      stall_gap = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Long receiver hold-off while the sender keeps offering transactions.
  initial begin
    hold_active = 1'b0;
    wait (hold_request);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Monitor: predict on input transactions, check output transactions.
  always @(posedge clk) begin : monitor
    alu_item_t   it;
    alu_result_t exp_res;
    in_accepted = rst_n && in_tvalid && in_tready;
    if (in_accepted) begin
      it = pending_ops.pop_front();
      expected_results.push_back(alu_predict(it));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result value=%h flags=%b", out_tdata, out_tuser));
      end else begin
        exp_res = expected_results.pop_front();
        if (out_tdata !== exp_res.value)
          note_mismatch($sformatf("value exp %h got %h", exp_res.value, out_tdata));
        if (out_tuser[0] !== exp_res.cmp)
          note_mismatch($sformatf("compare_true exp %b got %b", exp_res.cmp, out_tuser[0]));
        if (out_tuser[1] !== exp_res.sat)
          note_mismatch($sformatf("saturated exp %b got %b", exp_res.sat, out_tuser[1]));
        if (out_tuser[2] !== exp_res.dz)
          note_mismatch($sformatf("divide_by_zero exp %b got %b", exp_res.dz, out_tuser[2]));
      end
    end
  end

  // Stimulus sequence and end of test.
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    in_accepted    = 1'b0;
    idle_off       = 1'b0;
    hold_request   = 1'b0;
    send_gap       = 0;
    stall_gap      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases: saturation at both bounds, rounding ties, divide by zero,
    // every comparison, unary ops at the bounds and the unused opcode.
    push_item(OP_ADD, RAW_HI, 32'sd1);
    push_item(OP_ADD, RAW_LO, -32'sd1);
    push_item(OP_SUB, RAW_LO, 32'sd1);
    push_item(OP_SUB, RAW_HI, -32'sd1);
    push_item(OP_MUL, RAW_HI, RAW_HI);
    push_item(OP_MUL, RAW_LO, RAW_HI);
    push_item(OP_MUL, -32'sd1, 32'sd128);
    push_item(OP_MUL, 32'sh180, 32'sh280);
    push_item(OP_DIV, 32'sd256, 32'sd0);
    push_item(OP_DIV, RAW_LO, -32'sd1);
    push_item(OP_DIV, 32'sd1, 32'sd3);
    push_item(OP_DIV, -32'sd1, 32'sd512);
    push_item(OP_GT, RAW_HI, RAW_LO);
    push_item(OP_LT, RAW_LO, RAW_HI);
    push_item(OP_GE, 32'sd5, 32'sd5);
    push_item(OP_LE, RAW_HI, RAW_LO);
    push_item(OP_EQ, RAW_LO, RAW_LO);
    push_item(OP_NE, 32'sd0, 32'sd0);
    push_item(OP_INC, RAW_HI, RAW_LO);
    push_item(OP_DEC, RAW_LO, RAW_HI);
    push_item(OP_MIN, RAW_LO, RAW_HI);
    push_item(OP_MAX, RAW_LO, RAW_HI);
    push_item(OP_TO_INT, 32'sd128, 32'sd0);
    push_item(OP_TO_INT, -32'sd128, -32'sd1);
    push_item(OP_TO_INT, RAW_LO, 32'sd7);
    push_item(OP_UNUSED, RAW_HI, RAW_LO);

    // The sender pauses until every directed result has come back.
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);

    // Random traffic with idling and one long receiver hold-off.
    queue_random(450);
    hold_request = 1'b1;
    while (pending_ops.size() != 0) @(posedge clk);

    // Full-rate traffic to finish.
    idle_off = 1'b1;
    queue_random(250);
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(CLK_PERIOD * 200000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
